### rtl/ckle_pkg.sv
// Shared types and codes for the compact key list engine.
`timescale 1ns / 1ps
package ckle_pkg;

    localparam int KEY_W = 152;

    typedef logic [KEY_W-1:0] key_t;

    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_SEARCH = 3'd3;
    localparam logic [2:0] OP_COUNT  = 3'd4;
    localparam logic [2:0] OP_ALTER  = 3'd5;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;     // capture the beat and compare against every cell
        logic clear;    // empty the list
        logic remove;   // shift cells above the match down by one
        logic append;   // write the key into slot fill_count
        logic use_new;  // append takes the replacement key
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic hit;
        logic key_empty;
        logic new_empty;
        logic full;
    } stat_t;

    // Cut the key at KEY_BYTES and after its first zero byte.
    function automatic key_t normalize(input key_t k, input int key_bytes);
        key_t r;
        logic ended;
        logic [7:0] b;
        r = '0;
        ended = 1'b0;
        for (int i = 0; i < 19; i++) begin
            b = k[KEY_W-1-8*i -: 8];
            if (i >= key_bytes || ended)
                b = 8'h00;
            if (b == 8'h00)
                ended = 1'b1;
            r[KEY_W-1-8*i -: 8] = b;
        end
        return r;
    endfunction

endpackage

### rtl/ckle_ctrl.sv
// Controller state machine of the compact key list engine.
`timescale 1ns / 1ps
module ckle_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic [2:0]          op,
    input  ckle_pkg::stat_t     stat,
    input  logic                out_free,
    output ckle_pkg::cmd_t      cmd,
    output logic                busy,
    output logic                res_load,
    output logic [1:0]          res_status
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic       state_reg, state_next;
    logic [2:0] op_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            op_reg <= op;
    end

    assign busy = (state_reg == S_EXEC);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        res_load   = 1'b0;
        res_status = ckle_pkg::ST_DONE;
        cmd.load   = in_fire;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free) begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                    case (op_reg) inside
                        ckle_pkg::OP_CLEAR: cmd.clear = 1'b1;
                        ckle_pkg::OP_INSERT:
                        begin
                            if (stat.full)
                                res_status = ckle_pkg::ST_FULL;
                            else
                                cmd.append = !stat.key_empty;
                        end
                        ckle_pkg::OP_REMOVE, ckle_pkg::OP_ALTER:
                        begin
                            if (!stat.hit)
                                res_status = ckle_pkg::ST_MISSING;
                            else begin
                                cmd.remove  = 1'b1;
                                cmd.use_new = (op_reg == ckle_pkg::OP_ALTER);
                                cmd.append  = cmd.use_new && !stat.new_empty;
                            end
                        end
                        ckle_pkg::OP_SEARCH:
                            if (!stat.hit)
                                res_status = ckle_pkg::ST_MISSING;
                        default: ;
                    endcase
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

### rtl/ckle_datapath.sv
// Cell chain datapath: stored keys, parallel compare, shift and append.
`timescale 1ns / 1ps
module ckle_datapath
#(
    parameter int LIST_DEPTH = 64,
    parameter int KEY_BYTES  = 19
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  ckle_pkg::cmd_t                 cmd,
    input  ckle_pkg::key_t                 key_in,
    input  ckle_pkg::key_t                 new_in,
    output ckle_pkg::stat_t                stat,
    output logic [$clog2(LIST_DEPTH)-1:0]  hit_idx,
    output logic [$clog2(LIST_DEPTH+1)-1:0] fill
);

    localparam int IW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH+1);

    ckle_pkg::key_t            cell_reg [LIST_DEPTH];
    ckle_pkg::key_t            key_reg;
    ckle_pkg::key_t            new_reg;
    logic [CW-1:0]             fill_reg, fill_next;
    logic [LIST_DEPTH-1:0]     match_reg;
    logic                      kempty_reg, nempty_reg;
    logic [LIST_DEPTH-1:0]     above;
    logic [IW-1:0]             app_slot;
    ckle_pkg::key_t            app_key;
    ckle_pkg::key_t            key_n, new_n;

    assign key_n = ckle_pkg::normalize(key_in, KEY_BYTES);
    assign new_n = ckle_pkg::normalize(new_in, KEY_BYTES);

    // Registered compare of every occupied cell against the incoming key.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            match_reg  <= '0;
            kempty_reg <= 1'b1;
            nempty_reg <= 1'b1;
        end else if (cmd.load) begin
            for (int i = 0; i < LIST_DEPTH; i++)
                match_reg[i] <= (CW'(i) < fill_reg) && (cell_reg[i] == key_n)
                                && (key_n != '0);
            kempty_reg <= (key_n == '0);
            nempty_reg <= (new_n == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            key_reg <= key_n;
            new_reg <= new_n;
        end
    end

    // First match wins; cells at or above it shift down on remove.
    always_comb
    begin
        hit_idx = '0;
        for (int i = LIST_DEPTH-1; i >= 0; i--)
            if (match_reg[i])
                hit_idx = IW'(i);
        for (int i = 0; i < LIST_DEPTH; i++)
            above[i] = (IW'(i) >= hit_idx);
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.remove)
            fill_next = fill_next - 1'b1;
        app_slot = fill_next[IW-1:0];
        app_key  = cmd.use_new ? new_reg : key_reg;
        if (cmd.append)
            fill_next = fill_next + 1'b1;
        if (cmd.clear)
            fill_next = '0;
    end

    // Append takes the captured key, or the replacement key on alter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fill_reg <= '0;
            for (int i = 0; i < LIST_DEPTH; i++)
                cell_reg[i] <= '0;
        end else begin
            fill_reg <= fill_next;
            for (int i = 0; i < LIST_DEPTH; i++) begin
                if (cmd.clear)
                    cell_reg[i] <= '0;
                else if (cmd.append && app_slot == IW'(i))
                    cell_reg[i] <= app_key;
                else if (cmd.remove && above[i])
                    cell_reg[i] <= (i == LIST_DEPTH-1) ? '0 : cell_reg[(i+1) % LIST_DEPTH];
            end
        end
    end

    assign stat.hit       = |match_reg;
    assign stat.key_empty = kempty_reg;
    assign stat.new_empty = nempty_reg;
    assign stat.full      = (fill_reg >= CW'(LIST_DEPTH));
    assign fill           = fill_next;

endmodule

### rtl/compact_key_list_engine.sv
// Top level of the compact key list engine.
`timescale 1ns / 1ps
// A compact list of up to LIST_DEPTH keys of KEY_BYTES bytes, each key held
// as three words (bytes 0-7, 8-15, 16-18, first byte most significant).
// Keys are cut at KEY_BYTES and after their first zero byte; an all-zero
// key is never stored or found. Each input beat carries one opcode (clear,
// insert, remove, search, count, alter) and gives exactly one result beat
// with status, position and entry count. Each operation has a capture step,
// which takes the beat and compares the key against all cells at once, then
// an execute step, which shifts/appends and registers the result. A new beat
// is taken as soon as the controller is idle; a result left waiting stalls
// only the execute step, and no new beat is taken until it is done. Reset
// empties the list at once.
module compact_key_list_engine
#(
    parameter int LIST_DEPTH = 64,
    parameter int KEY_BYTES  = 19
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [63:0] key_word0,
    input  logic [63:0] key_word1,
    input  logic [23:0] key_word2,
    input  logic [63:0] new_word0,
    input  logic [63:0] new_word1,
    input  logic [23:0] new_word2,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [5:0]  position,
    output logic [6:0]  entry_count
);

    localparam int IW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH+1);

    ckle_pkg::cmd_t   cmd;
    ckle_pkg::stat_t  stat;
    logic             busy, res_load, in_fire, out_free;
    logic [1:0]       res_status;
    logic [IW-1:0]    hit_idx;
    logic [CW-1:0]    fill;
    logic [2:0]       op_reg;
    logic [CW-1:0]    app_pos;
    logic             out_valid_reg;
    logic [1:0]       status_reg;
    logic [5:0]       position_reg;
    logic [6:0]       count_reg;
    logic [CW-1:0]    pos_w;

    // The beat is captured on accept, so the next one may wait in the input.
    assign in_ready = !busy;
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    ckle_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .op         (opcode),
        .stat       (stat),
        .out_free   (out_free),
        .cmd        (cmd),
        .busy       (busy),
        .res_load   (res_load),
        .res_status (res_status)
    );

    ckle_datapath #(.LIST_DEPTH(LIST_DEPTH), .KEY_BYTES(KEY_BYTES)) u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .key_in  ({key_word0, key_word1, key_word2}),
        .new_in  ({new_word0, new_word1, new_word2}),
        .stat    (stat),
        .hit_idx (hit_idx),
        .fill    (fill)
    );

    always_ff @(posedge clk)
    begin
        if (in_fire)
            op_reg <= opcode;
    end

    // Slot reported by insert/alter is fill after any removal.
    assign app_pos = fill - CW'(cmd.append);

    always_comb
    begin
        pos_w = '0;
        if (res_status == ckle_pkg::ST_DONE) begin
            case (op_reg) inside
                ckle_pkg::OP_INSERT, ckle_pkg::OP_ALTER: pos_w = app_pos;
                ckle_pkg::OP_REMOVE, ckle_pkg::OP_SEARCH: pos_w = CW'(hit_idx);
                default: pos_w = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load) begin
            status_reg   <= res_status;
            position_reg <= 6'(pos_w);
            count_reg    <= 7'(fill);
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign position    = position_reg;
    assign entry_count = count_reg;

    // Never accept while an operation is in flight.
    assert property (@(posedge clk) disable iff (!rst_n) busy |-> !in_ready)
        else $error("input accepted while busy");
    // An accepted beat makes the controller busy on the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n) in_fire |=> busy)
        else $error("controller missed a beat");
    // Fill never passes the depth.
    assert property (@(posedge clk) disable iff (!rst_n) fill <= CW'(LIST_DEPTH))
        else $error("fill overflow");

endmodule

### dv/testbench.sv
// Self-checking testbench for the compact key list engine.
`timescale 1ns / 1ps
module testbench;

    localparam int DEPTH = 64;
    localparam int NBYTES = 19;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] position;
        logic [6:0] entry_count;
    } list_result_t;

    // Scoreboard: a shadow copy of the list plus the queue of results still owed.
    class key_list_scoreboard;
        ckle_pkg::key_t shadow[DEPTH];
        int unsigned used;
        list_result_t owed[$];
        int unsigned errors;

        function new();
            foreach (shadow[i]) shadow[i] = '0;
            used = 0;
            errors = 0;
        endfunction

        // Cut the key at NBYTES and after its first zero byte.
        function ckle_pkg::key_t trim_key(input ckle_pkg::key_t k);
            ckle_pkg::key_t r;
            logic ended;
            logic [7:0] b;
            r = '0;
            ended = 1'b0;
            for (int i = 0; i < 19; i++) begin
                b = k[ckle_pkg::KEY_W-1-8*i -: 8];
                if (i >= NBYTES || ended) b = 8'h00;
                if (b == 8'h00) ended = 1'b1;
                r[ckle_pkg::KEY_W-1-8*i -: 8] = b;
            end
            return r;
        endfunction

        function int find_slot(input ckle_pkg::key_t k);
            for (int i = 0; i < used; i++)
                if (shadow[i] == k) return i;
            return -1;
        endfunction

        function void drop_slot(input int idx);
            for (int i = idx; i + 1 < used; i++) shadow[i] = shadow[i+1];
            used--;
            shadow[used] = '0;
        endfunction

        function logic [1:0] append_slot(input ckle_pkg::key_t k, output int pos);
            if (used >= DEPTH)
            begin
                pos = 0;
                return ckle_pkg::ST_FULL;
            end
            pos = used;
            if (k == '0) return ckle_pkg::ST_DONE;
            shadow[used] = k;
            used++;
            return ckle_pkg::ST_DONE;
        endfunction

        // Note one accepted input beat and queue the result it must give.
        function void note_request(input logic [2:0] op, input ckle_pkg::key_t k,
                                   input ckle_pkg::key_t nk);
            ckle_pkg::key_t kt;
            list_result_t r;
            int idx;
            int pos;
            kt = trim_key(k);
            r.status = ckle_pkg::ST_DONE;
            pos = 0;
            case (op) inside
                ckle_pkg::OP_CLEAR:
                begin
                    foreach (shadow[i]) shadow[i] = '0;
                    used = 0;
                end
                ckle_pkg::OP_INSERT: r.status = append_slot(kt, pos);
                ckle_pkg::OP_REMOVE, ckle_pkg::OP_SEARCH, ckle_pkg::OP_ALTER:
                begin
                    idx = (kt == '0) ? -1 : find_slot(kt);
                    if (idx < 0) r.status = ckle_pkg::ST_MISSING;
                    else if (op == ckle_pkg::OP_SEARCH) pos = idx;
                    else if (op == ckle_pkg::OP_REMOVE)
                    begin
                        pos = idx;
                        drop_slot(idx);
                    end
                    else
                    begin
                        drop_slot(idx);
                        r.status = append_slot(trim_key(nk), pos);
                    end
                end
                default: ;
            endcase
            r.position = pos[5:0];
            r.entry_count = used[6:0];
            owed.push_back(r);
        endfunction

        function void check_result(input list_result_t got);
            list_result_t e;
            if (owed.size() == 0)
            begin
                $error("unexpected result beat status=%0d position=%0d count=%0d",
                       got.status, got.position, got.entry_count);
                errors++;
                return;
            end
            e = owed.pop_front();
            if (got.status !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, got.status);
                errors++;
            end
            if (got.position !== e.position)
            begin
                $error("position: expected %0d, got %0d", e.position, got.position);
                errors++;
            end
            if (got.entry_count !== e.entry_count)
            begin
                $error("entry_count: expected %0d, got %0d", e.entry_count, got.entry_count);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  opcode;
    logic [63:0] key_word0;
    logic [63:0] key_word1;
    logic [23:0] key_word2;
    logic [63:0] new_word0;
    logic [63:0] new_word1;
    logic [23:0] new_word2;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [5:0]  position;
    logic [6:0]  entry_count;

    compact_key_list_engine #(.LIST_DEPTH(DEPTH), .KEY_BYTES(NBYTES)) uut
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
        .key_word0(key_word0), .key_word1(key_word1), .key_word2(key_word2),
        .new_word0(new_word0), .new_word1(new_word1), .new_word2(new_word2),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .position(position), .entry_count(entry_count)
    );

    key_list_scoreboard board;
    int unsigned cycles;
    bit sender_calm;     // no idling on the send side during the calm stretch
    bit receiver_calm;
    ckle_pkg::key_t pool[8];       // a few recurring keys so searches and removes hit

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Build a key of a random length, with occasional junk after a zero byte.
    function automatic ckle_pkg::key_t random_key();
        ckle_pkg::key_t k;
        int len;
        k = '0;
        len = $urandom_range(0, 19);
        for (int i = 0; i < 19; i++)
            k[ckle_pkg::KEY_W-1-8*i -: 8] = (i < len) ? 8'($urandom_range(1, 255)) : 8'h00;
        if ($urandom_range(0, 7) == 0)
            for (int i = len + 1; i < 19; i++)
                k[ckle_pkg::KEY_W-1-8*i -: 8] = 8'($urandom());
        return k;
    endfunction

    // Mostly reuse pool keys, sometimes with their last byte randomised.
    function automatic ckle_pkg::key_t pick_key();
        ckle_pkg::key_t k;
        if ($urandom_range(0, 99) < 70)
        begin
            k = pool[$urandom_range(0, 7)];
            if ($urandom_range(0, 9) == 0) k[7:0] = 8'($urandom());
            return k;
        end
        return random_key();
    endfunction

    // Send one beat: valid held with a steady payload until the handshake.
    task automatic send_beat(input logic [2:0] op, input ckle_pkg::key_t k,
                             input ckle_pkg::key_t nk);
        if (!sender_calm)
            while ($urandom_range(0, 99) < 30)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid <= 1'b1;
        opcode <= op;
        {key_word0, key_word1, key_word2} <= k;
        {new_word0, new_word1, new_word2} <= nk;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_request(op, k, nk);
    endtask

    // Drop valid after the last accepted beat.
    task automatic stop_sending();
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (board.owed.size() != 0) @(posedge clk);
    endtask

    // Result side: random backpressure outside the calm stretch, check on every accepted beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_result('{status, position, entry_count});
            out_ready <= receiver_calm ? 1'b1 : ($urandom_range(0, 99) >= 30);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial
    begin
        ckle_pkg::key_t ones;
        logic [2:0] op;
        board = new();
        cycles = 0;
        sender_calm = 1'b0;
        receiver_calm = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        opcode = ckle_pkg::OP_CLEAR;
        {key_word0, key_word1, key_word2} = '0;
        {new_word0, new_word1, new_word2} = '0;
        foreach (pool[i]) pool[i] = random_key();
        ones = '1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty key, all-ones key, misses, hit, alter cases, junk opcodes.
        send_beat(ckle_pkg::OP_COUNT, '0, '0);
        send_beat(ckle_pkg::OP_SEARCH, ones, '0);
        send_beat(ckle_pkg::OP_INSERT, '0, '0);
        send_beat(ckle_pkg::OP_INSERT, ones, '0);
        send_beat(ckle_pkg::OP_INSERT, pool[0], '0);
        send_beat(ckle_pkg::OP_INSERT, {8'h41, 144'h0}, '0);
        send_beat(ckle_pkg::OP_SEARCH, ones, '0);
        send_beat(ckle_pkg::OP_SEARCH, '0, '0);
        send_beat(ckle_pkg::OP_REMOVE, '0, '0);
        send_beat(ckle_pkg::OP_ALTER, '0, ones);
        send_beat(ckle_pkg::OP_SEARCH, {8'h41, 8'h00, 136'h1234}, '0);
        send_beat(ckle_pkg::OP_ALTER, ones, pool[1]);
        send_beat(ckle_pkg::OP_ALTER, pool[0], '0);
        send_beat(ckle_pkg::OP_REMOVE, {8'h41, 144'h0}, '0);
        send_beat(ckle_pkg::OP_REMOVE, ones, '0);
        send_beat(3'd6, ones, ones);
        send_beat(3'd7, '0, '0);
        // Fill the list to overflow, then the full-list cases.
        for (int i = 0; i < DEPTH + 2; i++)
            send_beat(ckle_pkg::OP_INSERT, {8'h80, 8'(i + 1), 136'h0}, '0);
        send_beat(ckle_pkg::OP_SEARCH, {8'h80, 8'd64, 136'h0}, '0);
        send_beat(ckle_pkg::OP_ALTER, {8'h80, 8'd5, 136'h0}, ones);
        send_beat(ckle_pkg::OP_INSERT, ones, '0);
        send_beat(ckle_pkg::OP_ALTER, ones, pool[2]);
        send_beat(ckle_pkg::OP_CLEAR, ones, '0);

        // Pause the sender until every result is in.
        stop_sending();
        wait_drained();

        // Random part, with one stretch of no idling on either side.
        for (int n = 0; n < 420; n++)
        begin
            sender_calm = (n >= 200 && n < 280);
            receiver_calm = sender_calm;
            if (n % 100 == 50) pool[$urandom_range(0, 7)] = random_key();
            case ($urandom_range(0, 99)) inside
                [0:1]:   op = ckle_pkg::OP_CLEAR;
                [2:36]:  op = ckle_pkg::OP_INSERT;
                [37:56]: op = ckle_pkg::OP_REMOVE;
                [57:76]: op = ckle_pkg::OP_SEARCH;
                [77:84]: op = ckle_pkg::OP_COUNT;
                [85:97]: op = ckle_pkg::OP_ALTER;
                default: op = 3'($urandom_range(6, 7));
            endcase
            send_beat(op, pick_key(), pick_key());
        end
        sender_calm = 1'b0;
        receiver_calm = 1'b0;

        stop_sending();
        wait_drained();
        repeat (20) @(posedge clk);
        if (board.errors == 0 && board.owed.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule

### filelist.f
rtl/ckle_pkg.sv
rtl/ckle_ctrl.sv
rtl/ckle_datapath.sv
rtl/compact_key_list_engine.sv
dv/testbench.sv
